// ===== sv/unused_vertex_compaction_remap_core_assert.svh =====
`ifndef UNUSED_VERTEX_COMPACTION_REMAP_CORE_ASSERT_SVH
`define UNUSED_VERTEX_COMPACTION_REMAP_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UVC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uvc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define UVC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uvc assertion failed");

`endif

// ===== sv/uvc_pkg.sv =====
package uvc_pkg;

	localparam int MAX_V   = 4096;
	localparam int VIDX_W  = $clog2(MAX_V);
	localparam int VCNT_W  = $clog2(MAX_V + 1);
	localparam int ENTRY_W = VIDX_W + 1;

	typedef enum logic [1:0] {
		K_CLEAR   = 2'd0,
		K_MARK    = 2'd1,
		K_COMPACT = 2'd2,
		K_LOOKUP  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_NOTBUILT = 2'd2
	} status_t;

	typedef struct packed {
		logic [VIDX_W-1:0] new_index;
		logic              vertex_used;
		logic [VCNT_W-1:0] kept_count;
		logic              all_used;
		status_t           status;
	} res_t;

	typedef struct packed {
		logic               we;
		logic [VIDX_W-1:0]  waddr;
		logic [ENTRY_W-1:0] wdata;
		logic [VIDX_W-1:0]  raddr;
	} ram_req_t;

endpackage

// ===== sv/uvc_if.sv =====
interface uvc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] vertex_number;

	modport source (output valid, kind, vertex_number, input ready);
	modport sink (input valid, kind, vertex_number, output ready);
endinterface

interface uvc_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] new_index;
	logic        vertex_used;
	logic [12:0] kept_count;
	logic        all_used;
	logic [1:0]  status;

	modport source (output valid, new_index, vertex_used, kept_count, all_used, status,
		input ready);
	modport sink (input valid, new_index, vertex_used, kept_count, all_used, status,
		output ready);
endinterface

// ===== sv/unused_vertex_compaction_remap_core.sv =====
// Unused-vertex compaction with index remap. The used map and the remap table share one
// 4096 x 13 synchronous RAM (used bit plus new index). After reset the block runs a
// clearing pass over all 4096 entries of that RAM and takes no item meanwhile;
// configuration writes are taken at any time. An in-range mark sets its used bit and
// returns no result, an out-of-range mark returns a range status, and a lookup of a built
// table reads the RAM in S_LOOK. A clear sweeps all 4096 entries at one write per cycle.
// A compact streams the effective vertex range through the RAM, reading one entry and
// writing back the previous one each cycle. Results pass through an output register, so
// a result waiting on the result channel does not hold up the next item until that item
// has a result. Writing vertex_count invalidates the remap table but keeps the used map.
module unused_vertex_compaction_remap_core
	import uvc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	uvc_in_if.sink            items,
	uvc_out_if.source         results,
	input  logic              cfg_we,
	input  logic [VCNT_W-1:0] cfg_wdata
);

	logic [VCNT_W-1:0]  vcount_q;
	logic [VCNT_W-1:0]  count;
	ram_req_t           ram_req;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               res_valid;
	res_t               res;
	logic               res_ready;
	logic               out_vld_q;
	res_t               out_q;

	assign count = (vcount_q > VCNT_W'(MAX_V)) ? VCNT_W'(MAX_V) : vcount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCNT_W'(MAX_V);
		end else if (cfg_we) begin
			vcount_q <= cfg_wdata;
		end
	end

	uvc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_V)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	uvc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.count     (count),
		.cfg_we    (cfg_we),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// output beat register
	assign res_ready = !out_vld_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign results.valid       = out_vld_q;
	assign results.new_index   = out_q.new_index;
	assign results.vertex_used = out_q.vertex_used;
	assign results.kept_count  = out_q.kept_count;
	assign results.all_used    = out_q.all_used;
	assign results.status      = out_q.status;

endmodule

// ===== sv/uvc_ram.sv =====
module uvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/uvc_engine.sv =====
module uvc_engine
	import uvc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	uvc_in_if.sink             items,
	input  logic [VCNT_W-1:0]  count,
	input  logic               cfg_we,
	output ram_req_t           ram_req,
	input  logic [ENTRY_W-1:0] ram_rdata,
	output logic               res_valid,
	output res_t               res,
	input  logic               res_ready
);

	`include "unused_vertex_compaction_remap_core_assert.svh"

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_COMPACT,
		S_LOOK,
		S_RESULT
	} state_t;

	state_t              state_q;
	logic [VCNT_W-1:0]   cnt_q;
	logic                vld_s1;
	logic [VIDX_W-1:0]   addr_s1;
	logic [VCNT_W-1:0]   running_q;
	logic                table_valid_q;
	logic [VCNT_W-1:0]   kept_q;
	res_t                res_q;

	kind_t               kind;
	logic                accept;
	logic                in_range;
	logic                rd_issue;
	logic                compact_done;

	assign kind      = kind_t'(items.kind);
	assign items.ready = (state_q == S_IDLE);
	assign accept    = items.valid && items.ready;
	assign in_range  = {1'b0, items.vertex_number} < count;
	assign rd_issue  = (state_q == S_COMPACT) && (cnt_q < count);
	assign compact_done = (state_q == S_COMPACT) && !rd_issue && !vld_s1;
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = cnt_q[VIDX_W-1:0];
		ram_req.wdata = '0;
		ram_req.raddr = cnt_q[VIDX_W-1:0];
		unique case (state_q)
			S_CLR: begin
				ram_req.we = 1'b1;
			end
			S_IDLE: begin
				ram_req.raddr = items.vertex_number;
				ram_req.waddr = items.vertex_number;
				ram_req.wdata = {1'b1, {VIDX_W{1'b0}}};
				ram_req.we    = accept && (kind == K_MARK) && in_range;
			end
			S_COMPACT: begin
				ram_req.we    = vld_s1;
				ram_req.waddr = addr_s1;
				ram_req.wdata = {ram_rdata[VIDX_W], running_q[VIDX_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	// table valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_valid_q <= 1'b0;
		end else if (cfg_we) begin
			table_valid_q <= 1'b0;
		end else if (accept && ((kind == K_CLEAR) || ((kind == K_MARK) && in_range))) begin
			table_valid_q <= 1'b0;
		end else if (compact_done) begin
			table_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			cnt_q         <= '0;
			vld_s1        <= 1'b0;
			addr_s1       <= '0;
			running_q     <= '0;
			kept_q        <= '0;
			res_q         <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + VCNT_W'(1);
					if (cnt_q == VCNT_W'(MAX_V - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							K_CLEAR: begin
								cnt_q         <= '0;
								state_q       <= S_CLR;
							end
							K_MARK: begin
								if (!in_range) begin
									res_q.status <= ST_RANGE;
									state_q      <= S_RESULT;
								end
							end
							K_COMPACT: begin
								cnt_q     <= '0;
								running_q <= '0;
								vld_s1    <= 1'b0;
								state_q   <= S_COMPACT;
							end
							K_LOOKUP: begin
								priority if (!table_valid_q) begin
									res_q.status <= ST_NOTBUILT;
									state_q      <= S_RESULT;
								end else if (!in_range) begin
									res_q.status <= ST_RANGE;
									state_q      <= S_RESULT;
								end else begin
									state_q <= S_LOOK;
								end
							end
						endcase
					end
				end
				S_COMPACT: begin
					vld_s1  <= rd_issue;
					addr_s1 <= cnt_q[VIDX_W-1:0];
					if (rd_issue) begin
						cnt_q <= cnt_q + VCNT_W'(1);
					end
					if (vld_s1) begin
						running_q <= running_q + VCNT_W'(ram_rdata[VIDX_W]);
					end
					if (compact_done) begin
						kept_q             <= running_q;
						res_q.new_index    <= '0;
						res_q.vertex_used  <= 1'b0;
						res_q.kept_count   <= running_q;
						res_q.all_used     <= (running_q == count);
						res_q.status       <= ST_OK;
						state_q            <= S_RESULT;
					end
				end
				S_LOOK: begin
					res_q.new_index   <= ram_rdata[VIDX_W-1:0];
					res_q.vertex_used <= ram_rdata[VIDX_W];
					res_q.kept_count  <= kept_q;
					res_q.all_used    <= (kept_q == count);
					res_q.status      <= ST_OK;
					state_q           <= S_RESULT;
				end
				S_RESULT: begin
					if (res_ready) begin
						res_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// compact writes back behind its read pointer, never onto the entry being read
	`UVC_ASSERT_NOW(a_no_rw_collide, rd_issue && ram_req.we, ram_req.waddr != ram_req.raddr)
	`UVC_ASSERT_NOW(a_running_bound, state_q == S_COMPACT, running_q <= cnt_q)
	`UVC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_q))
	`UVC_ASSERT_NOW(a_valid_from_compact, $rose(table_valid_q), $past(state_q) == S_COMPACT)

endmodule
